[src/etb_pkg.sv]
// Package: shared types, constants and register map of the event timer block.
package etb_pkg;
    localparam int NUM_TIMERS   = 8;
    localparam int WIDE_COUNTER = 1;
    localparam int NT = (NUM_TIMERS > 8) ? 8 : ((NUM_TIMERS < 1) ? 1 : NUM_TIMERS);
    localparam int TW = (NT > 1) ? $clog2(NT) : 1;

    localparam logic [63:0] LOW32 = 64'h0000_0000_ffff_ffff;
    localparam logic [63:0] CNT_MASK = (WIDE_COUNTER != 0) ? ~64'h0 : LOW32;
    localparam logic [5:0] COUNTER_WORD = 6'(8'hf0 / 8);
    localparam logic [5:0] TIMER_BASE = 6'd32;
    localparam logic [7:0] TIMER_BITS = 8'((1 << NT) - 1);

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [5:0] ADDR_CAPS   = 6'd0;
    localparam logic [5:0] ADDR_CONFIG = 6'd2;
    localparam logic [5:0] ADDR_STATUS = 6'd4;

    localparam logic [1:0] SUB_CONF  = 2'd0;
    localparam logic [1:0] SUB_COMP  = 2'd1;
    localparam logic [1:0] SUB_ROUTE = 2'd2;

    localparam logic [1:0] CFG_PERIOD   = 2'd0;
    localparam logic [1:0] CFG_VENDOR   = 2'd1;
    localparam logic [1:0] CFG_REVISION = 2'd2;

    // timer control bit positions
    localparam int C_LEVEL    = 0;
    localparam int C_ENABLE   = 1;
    localparam int C_PERIODIC = 2;
    localparam int C_FORCE32  = 3;
    localparam int C_VALSET   = 4;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic exec;
        logic [1:0] command;
        logic [5:0] address;
        logic [63:0] write_data;
    } t_cmd;

    typedef struct packed {
        logic [63:0] read_data;
        logic [7:0] irq_level;
        logic [7:0] irq_pulse;
        logic bad_address;
    } t_result;
endpackage

[src/etb_if.sv]
// Interfaces: valid/ready channels for input items and result items.
`default_nettype none
interface etb_in_if;
    logic valid;
    logic ready;
    logic [1:0] command;
    logic [5:0] address;
    logic [63:0] write_data;
    modport source(output valid, command, address, write_data, input ready);
    modport sink(input valid, command, address, write_data, output ready);
endinterface

interface etb_out_if;
    logic valid;
    logic ready;
    logic [63:0] read_data;
    logic [7:0] irq_level;
    logic [7:0] irq_pulse;
    logic bad_address;
    modport source(output valid, read_data, irq_level, irq_pulse, bad_address, input ready);
    modport sink(input valid, read_data, irq_level, irq_pulse, bad_address, output ready);
endinterface
`default_nettype wire

[src/etb_ctrl.sv]
// Controller: accepts items, issues execute commands, holds results for output.
`default_nettype none
module etb_ctrl (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output logic o_exec
);
    import etb_pkg::*;
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) n_state = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready = i_out_ready;
                if (i_out_ready && !i_in_valid) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        o_exec = o_in_ready && i_in_valid;
    end
endmodule
`default_nettype wire

[src/etb_dp.sv]
// Datapath: counter, timers, register file and result register.
`default_nettype none
module etb_dp (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire etb_pkg::t_cmd i_cmd,
    input  wire logic [26:0] i_period_fs,
    input  wire logic [15:0] i_vendor,
    input  wire logic [7:0] i_revision,
    output etb_pkg::t_result o_res
);
    import etb_pkg::*;

    logic [63:0] r_count, n_count;
    logic r_gen, n_gen;
    logic [7:0] r_status, n_status;
    logic [5:0] r_ctrl [NT], n_ctrl [NT];
    logic [63:0] r_match [NT], n_match [NT];
    logic [63:0] r_step [NT], n_step [NT];
    t_result r_res, n_res;

    function automatic logic [63:0] tmask(input logic [5:0] c);
        return ((WIDE_COUNTER == 0) || c[C_FORCE32]) ? LOW32 : ~64'h0;
    endfunction

    logic [63:0] inc;
    logic [5:0] off;
    logic [TW-1:0] tn;
    logic [1:0] sub;
    logic is_timer;
    logic [5:0] nc;
    logic [63:0] tm;
    logic [7:0] lvl;

    always_comb begin
        n_count = r_count;
        n_gen = r_gen;
        n_status = r_status;
        n_ctrl = r_ctrl;
        n_match = r_match;
        n_step = r_step;
        n_res = r_res;
        inc = (r_count + 64'd1) & CNT_MASK;
        off = i_cmd.address - TIMER_BASE;
        tn = off[2 +: TW];
        sub = off[1:0];
        is_timer = (i_cmd.address >= TIMER_BASE) && ({3'd0, off[5:2]} < 7'(NT))
                   && (sub != 2'd3);
        nc = 6'd0;
        tm = 64'd0;
        n_res.read_data = 64'd0;
        n_res.irq_pulse = 8'd0;
        n_res.bad_address = 1'b0;
        if (i_cmd.command == CMD_TICK) begin
            if (r_gen) begin
                n_count = inc;
                for (int n = 0; n < NT; n++) begin
                    if ((inc & tmask(r_ctrl[n])) == (r_match[n] & tmask(r_ctrl[n]))) begin
                        if (r_ctrl[n][C_ENABLE]) begin
                            if (r_ctrl[n][C_LEVEL]) n_status[n] = 1'b1;
                            else n_res.irq_pulse[n] = 1'b1;
                        end
                        if (r_ctrl[n][C_PERIODIC])
                            n_match[n] = (r_match[n] + r_step[n]) & tmask(r_ctrl[n]);
                    end
                end
            end
        end else if (i_cmd.command == CMD_READ || i_cmd.command == CMD_WRITE) begin
            if (i_cmd.address == ADDR_CAPS) begin
                n_res.read_data = {5'd0, i_period_fs, i_vendor, 2'd0,
                                   1'(WIDE_COUNTER != 0), 5'(NT - 1), i_revision};
            end else if (i_cmd.address == ADDR_CONFIG) begin
                if (i_cmd.command == CMD_WRITE) n_gen = i_cmd.write_data[0];
                n_res.read_data = {63'd0, r_gen};
            end else if (i_cmd.address == ADDR_STATUS) begin
                if (i_cmd.command == CMD_WRITE)
                    n_status = r_status & ~(i_cmd.write_data[7:0] & TIMER_BITS);
                n_res.read_data = {56'd0, r_status};
            end else if (i_cmd.address == COUNTER_WORD) begin
                if (i_cmd.command == CMD_WRITE) n_count = i_cmd.write_data & CNT_MASK;
                n_res.read_data = r_count;
            end else if (is_timer) begin
                tm = tmask(r_ctrl[tn]);
                if (sub == SUB_CONF) begin
                    n_res.read_data = {55'd0, r_ctrl[tn][C_FORCE32], 2'd0,
                                       1'(WIDE_COUNTER != 0), 1'b1, r_ctrl[tn][C_PERIODIC],
                                       r_ctrl[tn][C_ENABLE], r_ctrl[tn][C_LEVEL], 1'b0};
                    if (i_cmd.command == CMD_WRITE) begin
                        nc[C_LEVEL] = i_cmd.write_data[1];
                        nc[C_ENABLE] = i_cmd.write_data[2];
                        nc[C_PERIODIC] = i_cmd.write_data[3];
                        nc[C_FORCE32] = i_cmd.write_data[8] && (WIDE_COUNTER != 0);
                        nc[C_VALSET] = i_cmd.write_data[6];
                        n_ctrl[tn] = nc;
                        n_match[tn] = r_match[tn] & tmask(nc);
                        n_step[tn] = r_step[tn] & tmask(nc);
                    end
                end else if (sub == SUB_COMP) begin
                    n_res.read_data = r_match[tn] & tm;
                    if (i_cmd.command == CMD_WRITE) begin
                        if (!r_ctrl[tn][C_PERIODIC] || r_ctrl[tn][C_VALSET])
                            n_match[tn] = i_cmd.write_data & tm;
                        n_step[tn] = i_cmd.write_data & tm;
                        n_ctrl[tn][C_VALSET] = 1'b0;
                    end
                end
            end else begin
                n_res.bad_address = 1'b1;
            end
            if (i_cmd.command == CMD_WRITE) n_res.read_data = 64'd0;
        end
        lvl = 8'd0;
        for (int n = 0; n < NT; n++)
            lvl[n] = n_ctrl[n][C_LEVEL] && n_ctrl[n][C_ENABLE];
        n_res.irq_level = n_status & lvl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 64'd0;
            r_gen <= 1'b0;
            r_status <= 8'd0;
            for (int n = 0; n < NT; n++) begin
                r_ctrl[n] <= 6'd0;
                r_match[n] <= CNT_MASK;
                r_step[n] <= 64'd0;
            end
        end else if (i_cmd.exec) begin
            r_count <= n_count;
            r_gen <= n_gen;
            r_status <= n_status;
            r_ctrl <= n_ctrl;
            r_match <= n_match;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) r_res <= n_res;
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

[src/event_timer_block_core.sv]
// Top level: event timer block with item channels and APB configuration port.
// Usage:
//   in_ch carries one item per handshake: a tick, a register read or a write.
//   out_ch returns exactly one result item per input item, in order.
//   Each item is executed in the cycle it is accepted; its result is valid in
//   the next cycle and held in the output register until taken.
//   Throughput: one item per cycle while the receiver takes results at once;
//   the result is captured by the single register stage after the
//   timer compare and register-file update.
//   A new item is accepted in the same cycle the waiting result is taken.
//   When the receiver stalls, in_ch.ready drops and the result holds.
//   APB writes set clock period, vendor code and revision reported in the
//   capabilities word; reads return them. pready is always high.
//   Reset (i_rst_n low, synchronous) clears the counter, enable, status and
//   timer control, sets comparators to all ones and periods to zero, and
//   restores the configuration register defaults. No clearing pass is needed.
`default_nettype none
module event_timer_block_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    etb_in_if.sink in_ch,
    etb_out_if.source out_ch,
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [3:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    import etb_pkg::*;

    logic [26:0] r_period;
    logic [15:0] r_vendor;
    logic [7:0] r_revision;
    logic exec;
    t_cmd cmd;
    t_result res;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 27'd69841279;
            r_vendor <= 16'd32902;
            r_revision <= 8'd1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                CFG_PERIOD: r_period <= pwdata[26:0];
                CFG_VENDOR: r_vendor <= pwdata[15:0];
                CFG_REVISION: r_revision <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            CFG_PERIOD: prdata = {5'd0, r_period};
            CFG_VENDOR: prdata = {16'd0, r_vendor};
            CFG_REVISION: prdata = {24'd0, r_revision};
            default: prdata = 32'd0;
        endcase
    end

    etb_ctrl u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid),
        .i_out_ready(out_ch.ready),
        .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid),
        .o_exec(exec)
    );

    assign cmd = '{exec: exec, command: in_ch.command, address: in_ch.address,
                   write_data: in_ch.write_data};

    etb_dp u_dp (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd(cmd),
        .i_period_fs(r_period),
        .i_vendor(r_vendor),
        .i_revision(r_revision),
        .o_res(res)
    );

    assign out_ch.read_data = res.read_data;
    assign out_ch.irq_level = res.irq_level;
    assign out_ch.irq_pulse = res.irq_pulse;
    assign out_ch.bad_address = res.bad_address;
endmodule
`default_nettype wire

[dv/etb_checker.sv]
// Checker: watches the event timer block's item channels, predicts every result and compares it.
`default_nettype none
module etb_checker
    import etb_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    etb_in_if in_ch,
    etb_out_if out_ch,
    input wire logic [26:0] i_cfg_period,
    input wire logic [15:0] i_cfg_vendor,
    input wire logic [7:0] i_cfg_revision,
    output int o_errors,
    output int o_pending,
    output int o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0] count_q;
    logic        enable_q;
    logic [7:0]  status_q;
    logic [4:0]  ctrl_q [8];
    logic [63:0] match_q [8];
    logic [63:0] step_q [8];
    t_result     expected_q [$];

    function automatic logic [63:0] width_mask(int n);
        if (WIDE_COUNTER == 0 || ctrl_q[n][C_FORCE32]) begin
            return LOW32;
        end
        return ~64'h0;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    task automatic predict(logic [1:0] cmd, logic [5:0] addr, logic [63:0] wd);
        t_result r;
        int n;
        logic [1:0] sub;
        logic [63:0] v;
        logic [7:0] lm;
        r = '0;
        if (cmd == CMD_TICK) begin
            if (enable_q) begin
                count_q = (count_q + 1) & CNT_MASK;
                for (int t = 0; t < NT; t++) begin
                    v = width_mask(t);
                    if ((count_q & v) == (match_q[t] & v)) begin
                        if (ctrl_q[t][C_ENABLE]) begin
                            if (ctrl_q[t][C_LEVEL]) status_q[t] = 1'b1;
                            else r.irq_pulse[t] = 1'b1;
                        end
                        if (ctrl_q[t][C_PERIODIC]) match_q[t] = (match_q[t] + step_q[t]) & v;
                    end
                end
            end
        end else if (cmd == CMD_READ || cmd == CMD_WRITE) begin
            if (addr == ADDR_CAPS) begin
                r.read_data = {5'b0, i_cfg_period, i_cfg_vendor, 2'b0, 1'(WIDE_COUNTER != 0),
                    5'(NT - 1), i_cfg_revision};
            end else if (addr == ADDR_CONFIG) begin
                if (cmd == CMD_WRITE) enable_q = wd[0];
                r.read_data = 64'(enable_q);
            end else if (addr == ADDR_STATUS) begin
                if (cmd == CMD_WRITE) status_q &= ~(wd[7:0] & TIMER_BITS);
                r.read_data = 64'(status_q);
            end else if (addr == COUNTER_WORD) begin
                if (cmd == CMD_WRITE) count_q = wd & CNT_MASK;
                r.read_data = count_q;
            end else if (addr < TIMER_BASE) begin
                r.bad_address = 1'b1;
            end else begin
                n = int'(addr - TIMER_BASE) >> 2;
                sub = 2'(addr - TIMER_BASE);
                if (n >= NT || sub == 2'd3) begin
                    r.bad_address = 1'b1;
                end else if (sub == SUB_CONF) begin
                    if (cmd == CMD_WRITE) begin
                        ctrl_q[n] = '0;
                        ctrl_q[n][C_LEVEL] = wd[1];
                        ctrl_q[n][C_ENABLE] = wd[2];
                        ctrl_q[n][C_PERIODIC] = wd[3];
                        ctrl_q[n][C_FORCE32] = wd[8] && (WIDE_COUNTER != 0);
                        ctrl_q[n][C_VALSET] = wd[6];
                        match_q[n] &= width_mask(n);
                        step_q[n] &= width_mask(n);
                    end
                    r.read_data = {55'b0, ctrl_q[n][C_FORCE32], 2'b0, 1'(WIDE_COUNTER != 0), 1'b1,
                        ctrl_q[n][C_PERIODIC], ctrl_q[n][C_ENABLE], ctrl_q[n][C_LEVEL], 1'b0};
                end else if (sub == SUB_COMP) begin
                    if (cmd == CMD_WRITE) begin
                        v = wd & width_mask(n);
                        if (!ctrl_q[n][C_PERIODIC] || ctrl_q[n][C_VALSET]) match_q[n] = v;
                        step_q[n] = v;
                        ctrl_q[n][C_VALSET] = 1'b0;
                    end
                    r.read_data = match_q[n] & width_mask(n);
                end
            end
            if (cmd == CMD_WRITE) r.read_data = '0;
        end
        lm = '0;
        for (int t = 0; t < NT; t++) lm[t] = ctrl_q[t][C_LEVEL] & ctrl_q[t][C_ENABLE];
        r.irq_level = status_q & lm;
        expected_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            count_q = '0;
            enable_q = 1'b0;
            status_q = '0;
            for (int t = 0; t < 8; t++) begin
                ctrl_q[t] = '0;
                match_q[t] = CNT_MASK;
                step_q[t] = '0;
            end
            expected_q.delete();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                o_results++;
                if (expected_q.size() == 0) begin
                    report("unexpected item", out_ch.read_data, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (out_ch.read_data !== want.read_data)
                        report("read_data", out_ch.read_data, want.read_data);
                    if (out_ch.irq_level !== want.irq_level)
                        report("irq_level", 64'(out_ch.irq_level), 64'(want.irq_level));
                    if (out_ch.irq_pulse !== want.irq_pulse)
                        report("irq_pulse", 64'(out_ch.irq_pulse), 64'(want.irq_pulse));
                    if (out_ch.bad_address !== want.bad_address)
                        report("bad_address", 64'(out_ch.bad_address), 64'(want.bad_address));
                end
            end
            if (in_ch.valid && in_ch.ready)
                predict(in_ch.command, in_ch.address, in_ch.write_data);
        end
        o_pending = expected_q.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_results = 0;
    end
endmodule
`default_nettype wire

[dv/tb_top.sv]
// Testbench top: drives items and configuration writes into the event timer block and gives the verdict.
`default_nettype none
module tb_top;
    import etb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic [26:0] cfg_period = 27'd69841279;
    logic [15:0] cfg_vendor = 16'd32902;
    logic [7:0] cfg_revision = 8'd1;
    int errors, pending, results;
    bit idle_on = 1'b1;
    bit hold_long = 1'b0;
    int item_cnt = 0;

    etb_in_if in_ch();
    etb_out_if out_ch();

    event_timer_block_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    etb_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .i_cfg_period(cfg_period), .i_cfg_vendor(cfg_vendor), .i_cfg_revision(cfg_revision),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.command = '0;
        in_ch.address = '0;
        in_ch.write_data = '0;
        out_ch.ready = 1'b0;
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int gap;
        @(negedge i_clk);
        forever begin
            if (hold_long) begin
                out_ch.ready = 1'b0;
                repeat (60) @(negedge i_clk);
                hold_long = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 17);
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end else begin
                out_ch.ready = 1'b1;
                @(negedge i_clk);
            end
        end
    end

    task automatic send(logic [1:0] cmd, logic [5:0] addr, logic [63:0] wd);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.command = cmd;
        in_ch.address = addr;
        in_ch.write_data = wd;
        @(posedge i_clk iff in_ch.ready);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        item_cnt++;
    endtask

    task automatic apb_write(logic [3:0] addr, logic [31:0] data);
        psel = 1'b1;
        paddr = addr;
        pwdata = data;
        pwrite = 1'b1;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk iff pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (addr)
            4'(CFG_PERIOD * 4):  cfg_period = data[26:0];
            4'(CFG_VENDOR * 4):  cfg_vendor = data[15:0];
            default:             cfg_revision = data[7:0];
        endcase
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] near_count(logic [63:0] base);
        return base + 64'($urandom_range(1, 12));
    endfunction

    // one programmed timer scenario: setup, ticks, reads, status clear
    task automatic scenario();
        logic [5:0] tb;
        logic [63:0] start;
        int ticks;
        tb = TIMER_BASE + 6'($urandom_range(0, 7) * 4);
        start = ($urandom_range(0, 3) == 0) ? {32'hffff_ffff, 32'hffff_fff0 | 32'($urandom_range(0, 15))}
                : (($urandom_range(0, 2) == 0) ? {32'($urandom), 32'hffff_fff8} : 64'($urandom_range(0, 40)));
        send(CMD_WRITE, ADDR_CONFIG, 64'd0);
        send(CMD_WRITE, COUNTER_WORD, start);
        send(CMD_WRITE, tb, rand64() & ~64'h0 ^ ({$urandom} & 64'h1f7 ^ 64'($urandom_range(0, 1)) << 6));
        send(CMD_WRITE, tb + 6'd1, near_count(start) ^ ($urandom_range(0, 3) == 0 ? rand64() & 64'hffff_ffff_0000_0000 : 64'd0));
        if ($urandom_range(0, 1)) send(CMD_WRITE, tb + 6'd1, 64'($urandom_range(1, 6)));
        send(CMD_WRITE, ADDR_CONFIG, rand64() | 64'($urandom_range(0, 3) != 0));
        ticks = $urandom_range(4, 24);
        for (int i = 0; i < ticks; i++) begin
            if ($urandom_range(0, 5) == 0) send(CMD_READ, 6'($urandom_range(0, 63)), rand64());
            else send(CMD_TICK, 6'($urandom), rand64());
        end
        send(CMD_READ, ADDR_STATUS, '0);
        send(CMD_READ, tb, '0);
        send(CMD_READ, tb + 6'd1, '0);
        send(CMD_WRITE, ADDR_STATUS, rand64());
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: the global registers, timers 0 and 1, extremes, unmapped offsets, unknown command
        send(CMD_READ, ADDR_CAPS, '0);
        send(CMD_WRITE, ADDR_CAPS, ~64'h0);
        send(CMD_READ, 6'd1, '0);
        send(CMD_WRITE, 6'd63, ~64'h0);
        send(CMD_READ, 6'd35, '0);
        send(CMD_READ, 6'd34, '0);
        send(2'd3, 6'd2, ~64'h0);
        send(CMD_WRITE, COUNTER_WORD, 64'hffff_ffff_ffff_fffd);
        send(CMD_WRITE, 6'd32, 64'h0000_0000_0000_0106);
        send(CMD_WRITE, 6'd33, 64'hffff_ffff_ffff_fffe);
        send(CMD_WRITE, 6'd36, 64'h4e);
        send(CMD_WRITE, 6'd37, 64'hffff_ffff_ffff_ffff);
        send(CMD_WRITE, 6'd37, 64'h3);
        send(CMD_WRITE, ADDR_CONFIG, 64'h1);
        repeat (5) send(CMD_TICK, 6'h3f, ~64'h0);
        send(CMD_READ, ADDR_STATUS, '0);
        send(CMD_READ, 6'd32, '0);
        send(CMD_READ, 6'd37, '0);
        send(CMD_WRITE, ADDR_STATUS, ~64'h0);
        send(CMD_READ, COUNTER_WORD, '0);
        drain();

        apb_write(4'(CFG_PERIOD * 4), 32'd1);
        apb_write(4'(CFG_VENDOR * 4), 32'h0);
        apb_write(4'(CFG_REVISION * 4), 32'hff);
        send(CMD_READ, ADDR_CAPS, '0);
        drain();
        apb_write(4'(CFG_PERIOD * 4), 32'd100000000);
        apb_write(4'(CFG_VENDOR * 4), 32'hffff);
        apb_write(4'(CFG_REVISION * 4), 32'h0);
        send(CMD_READ, ADDR_CAPS, '0);

        hold_long = 1'b1;
        while (item_cnt < 400) begin
            if ($urandom_range(0, 9) == 0) send(2'($urandom), 6'($urandom), rand64());
            else scenario();
        end
        drain();
        apb_write(4'(CFG_PERIOD * 4), 32'($urandom_range(1, 100000000)));
        apb_write(4'(CFG_VENDOR * 4), $urandom);
        apb_write(4'(CFG_REVISION * 4), $urandom);
        send(CMD_READ, ADDR_CAPS, '0);
        while (item_cnt < 620) scenario();
        idle_on = 1'b0;
        while (item_cnt < 735) scenario();

        fork
            begin
                while (pending != 0) @(negedge i_clk);
                repeat (10) @(negedge i_clk);
            end
            begin
                repeat (2000) @(negedge i_clk);
            end
        join_any
        $display("covered %0d items and %0d results across ticks, reads, writes", item_cnt, results);
        $display("and three capability settings incl. field extremes");
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
